@@ hdl/lss_pkg.sv @@
// lss_pkg: shared sizes, operation and status codes, and the controller to
// datapath command and status structures of the lifo stack with search.
// Depends on nothing; other sources but lss_ram use it by scoped names.
package lss_pkg;

   // stack geometry
   localparam int DEPTH  = 16;
   localparam int WORD_W = 32;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // operation codes of a request transaction
   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_POP    = 3'd1;
   localparam logic [2:0] OP_PEEK   = 3'd2;
   localparam logic [2:0] OP_LIST   = 3'd3;
   localparam logic [2:0] OP_SEARCH = 3'd4;

   // response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_PEEK,
      ST_LIST,
      ST_SEARCH
   } state_type;

   // what the datapath loads into the response registers
   typedef enum logic [2:0] {
      RSP_NONE,
      RSP_PUSH,
      RSP_EMPTY,
      RSP_FULL,
      RSP_READ,
      RSP_LIST,
      RSP_SEARCH
   } rsp_sel_type;

   // commands from controller to datapath
   typedef struct packed {
      logic        push_wr;
      logic        ptr_start;
      logic        ptr_step;
      logic        cnt_dec;
      logic        key_load;
      logic        hit_acc;
      rsp_sel_type rsp_sel;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic ptr_zero;
   } stat_type;

endpackage

@@ hdl/lss_ram.sv @@
// lss_ram: generic single-write, single-read memory with registered read data.
// Depends on nothing.
module lss_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lss_ctrl.sv @@
// lss_ctrl: state machine that sequences push, pop, peek, list and search.
// Depends on lss_pkg; drives the command struct of lss_dp.
module lss_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [2:0]        req_operation,
   input  lss_pkg::stat_type stat,
   output lss_pkg::cmd_type  cmd,
   output logic              busy
);

   lss_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lss_pkg::ST_IDLE: begin
            if (start && !stat.empty) begin
               case (req_operation)
                  lss_pkg::OP_POP:    state_in = lss_pkg::ST_POP;
                  lss_pkg::OP_PEEK:   state_in = lss_pkg::ST_PEEK;
                  lss_pkg::OP_LIST:   state_in = lss_pkg::ST_LIST;
                  lss_pkg::OP_SEARCH: state_in = lss_pkg::ST_SEARCH;
                  default:            state_in = lss_pkg::ST_IDLE;
               endcase
            end
         end
         lss_pkg::ST_POP, lss_pkg::ST_PEEK: begin
            state_in = lss_pkg::ST_IDLE;
         end
         lss_pkg::ST_LIST, lss_pkg::ST_SEARCH: begin
            if (stat.ptr_zero) begin
               state_in = lss_pkg::ST_IDLE;
            end
         end
         default: state_in = lss_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         lss_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               unique case (req_operation)
                  lss_pkg::OP_PUSH: begin
                     if (stat.full) begin
                        cmd.rsp_sel = lss_pkg::RSP_FULL;
                     end else begin
                        cmd.push_wr = 1'b1;
                        cmd.rsp_sel = lss_pkg::RSP_PUSH;
                     end
                  end
                  lss_pkg::OP_POP, lss_pkg::OP_PEEK, lss_pkg::OP_LIST: begin
                     if (stat.empty) begin
                        cmd.rsp_sel = lss_pkg::RSP_EMPTY;
                     end else begin
                        cmd.ptr_start = 1'b1;
                     end
                  end
                  lss_pkg::OP_SEARCH: begin
                     if (stat.empty) begin
                        cmd.rsp_sel = lss_pkg::RSP_EMPTY;
                     end else begin
                        cmd.ptr_start = 1'b1;
                        cmd.key_load  = 1'b1;
                     end
                  end
                  // undefined operations are dropped
                  default: cmd = '0;
               endcase
            end
         end
         lss_pkg::ST_POP: begin
            cmd.rsp_sel = lss_pkg::RSP_READ;
            cmd.cnt_dec = 1'b1;
         end
         lss_pkg::ST_PEEK: begin
            cmd.rsp_sel = lss_pkg::RSP_READ;
         end
         lss_pkg::ST_LIST: begin
            cmd.rsp_sel  = lss_pkg::RSP_LIST;
            cmd.ptr_step = !stat.ptr_zero;
         end
         lss_pkg::ST_SEARCH: begin
            cmd.hit_acc = 1'b1;
            if (stat.ptr_zero) begin
               cmd.rsp_sel = lss_pkg::RSP_SEARCH;
            end else begin
               cmd.ptr_step = 1'b1;
            end
         end
         default: busy = 1'b1;
      endcase
   end

endmodule

@@ hdl/lss_dp.sv @@
// lss_dp: stack datapath: word count, entry memory, walk pointer, search
// compare and response registers. Depends on lss_pkg and lss_ram.
module lss_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  lss_pkg::cmd_type                    cmd,
   input  logic signed [lss_pkg::WORD_W-1:0]   req_value,
   output lss_pkg::stat_type                   stat,
   output logic                                rsp_strobe,
   output logic        [1:0]                   rsp_status,
   output logic signed [lss_pkg::WORD_W-1:0]   rsp_word,
   output logic                                rsp_found,
   output logic                                rsp_last
);

   logic [lss_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [lss_pkg::ADDR_W-1:0] ptr_ff, ptr_in;
   logic [lss_pkg::WORD_W-1:0] key_ff, key_in;
   logic                       hit_ff, hit_in;
   logic [lss_pkg::WORD_W-1:0] rd_data;
   logic                       match;

   logic                       strobe_ff, strobe_in;
   logic [1:0]                 status_ff, status_in;
   logic [lss_pkg::WORD_W-1:0] word_ff, word_in;
   logic                       found_ff, found_in;
   logic                       last_ff, last_in;

   // entry memory: written at the count, read at the next walk pointer value
   lss_ram #(
      .WIDTH (lss_pkg::WORD_W),
      .DEPTH (lss_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.push_wr),
      .wr_addr (count_ff[lss_pkg::ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_addr (ptr_in),
      .rd_data (rd_data)
   );

   // status toward the controller
   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == lss_pkg::CNT_W'(lss_pkg::DEPTH));
   assign stat.ptr_zero = (ptr_ff == '0);

   assign match = (rd_data == key_ff);

   // count, pointer, key and hit flag
   always_comb begin
      count_in = count_ff;
      if (cmd.push_wr) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - 1'b1;
      end

      ptr_in = ptr_ff;
      if (cmd.ptr_start) begin
         ptr_in = lss_pkg::ADDR_W'(count_ff - 1'b1);
      end else if (cmd.ptr_step) begin
         ptr_in = ptr_ff - 1'b1;
      end

      key_in = cmd.key_load ? req_value : key_ff;

      hit_in = hit_ff;
      if (cmd.ptr_start) begin
         hit_in = 1'b0;
      end else if (cmd.hit_acc) begin
         hit_in = hit_ff | match;
      end
   end

   // response register load
   always_comb begin
      strobe_in = 1'b1;
      status_in = lss_pkg::STATUS_OK;
      word_in   = '0;
      found_in  = 1'b0;
      last_in   = 1'b1;
      unique case (cmd.rsp_sel)
         lss_pkg::RSP_NONE: begin
            strobe_in = 1'b0;
            status_in = status_ff;
            word_in   = word_ff;
            found_in  = found_ff;
            last_in   = last_ff;
         end
         lss_pkg::RSP_PUSH:   word_in   = req_value;
         lss_pkg::RSP_EMPTY:  status_in = lss_pkg::STATUS_EMPTY;
         lss_pkg::RSP_FULL:   status_in = lss_pkg::STATUS_FULL;
         lss_pkg::RSP_READ:   word_in   = rd_data;
         lss_pkg::RSP_LIST: begin
            word_in = rd_data;
            last_in = (ptr_ff == '0);
         end
         lss_pkg::RSP_SEARCH: found_in  = hit_ff | match;
         default:             strobe_in = 1'b0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      key_ff    <= key_in;
      hit_ff    <= hit_in;
      status_ff <= status_in;
      word_ff   <= word_in;
      found_ff  <= found_in;
      last_ff   <= last_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_word   = word_ff;
   assign rsp_found  = found_ff;
   assign rsp_last   = last_ff;

endmodule

@@ hdl/lifo_stack_with_search.sv @@
// A push, or a pop, peek, list or search on an empty stack, answers in the cycle
// after start and keeps busy low, so these run one per cycle. Pop and peek pass
// through one memory read before the response register. List and search walk
// the N stored words through the single registered read port, list giving one
// result per cycle. Reset (synchronous, active high) empties the stack and clears
// the strobe. Results cannot be stalled; each is shown for one cycle on rsp_strobe.
module lifo_stack_with_search (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic        [2:0]                 req_operation,
   input  logic signed [lss_pkg::WORD_W-1:0] req_value,
   output logic                              rsp_strobe,
   output logic        [1:0]                 rsp_status,
   output logic signed [lss_pkg::WORD_W-1:0] rsp_word,
   output logic                              rsp_found,
   output logic                              rsp_last
);

   lss_pkg::cmd_type  cmd;
   lss_pkg::stat_type stat;

   // sequencer
   lss_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .stat          (stat),
      .cmd           (cmd),
      .busy          (busy)
   );

   // storage and response path
   lss_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_value  (req_value),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_status (rsp_status),
      .rsp_word   (rsp_word),
      .rsp_found  (rsp_found),
      .rsp_last   (rsp_last)
   );

endmodule

@@ hdl/lss_checker.sv @@
// lss_checker: port-level assertions for lifo_stack_with_search, bound to it.
// Depends on lss_pkg and the top level's ports.
module lss_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic        [2:0]                 req_operation,
   input logic signed [lss_pkg::WORD_W-1:0] req_value,
   input logic                              rsp_strobe,
   input logic        [1:0]                 rsp_status,
   input logic signed [lss_pkg::WORD_W-1:0] rsp_word,
   input logic                              rsp_found,
   input logic                              rsp_last
);

   // reset leaves the block idle with no response pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("response or busy after reset");

   // a push always answers with a single final transaction on the next cycle
   a_push_answer: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_operation == lss_pkg::OP_PUSH |=> rsp_strobe && rsp_last)
      else $error("push did not answer next cycle");

   // empty or full answers are final and carry no word or hit
   a_error_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != lss_pkg::STATUS_OK
         |-> rsp_last && rsp_word == '0 && !rsp_found)
      else $error("malformed empty or full response");

   // list entries stream back to back while the block stays busy
   a_list_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> busy ##1 rsp_strobe)
      else $error("list stream broken");

   // the found flag only comes with a final ok answer that has no word
   a_found_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_found |-> rsp_last && rsp_word == '0)
      else $error("found flag on non-search response");

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_operation (req_operation),
   .req_value     (req_value),
   .rsp_strobe    (rsp_strobe),
   .rsp_status    (rsp_status),
   .rsp_word      (rsp_word),
   .rsp_found     (rsp_found),
   .rsp_last      (rsp_last)
);

@@ bench/lifo_stack_with_search_tb.sv @@
// lifo_stack_with_search_tb: self-checking bench for the lifo stack with search.
// Drives push, pop, peek, list and search transactions with random gaps and
// checks every response against a behavioral stack model. Depends on lss_pkg.
module lifo_stack_with_search_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // operation codes the block must ignore
   localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
   localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

   localparam int RANDOM_ITEMS = 260;
   localparam int DRAIN_CYCLES = 2 * lss_pkg::DEPTH + 8;

   // one expected response
   typedef struct packed {
      logic [1:0]                 status;
      logic [lss_pkg::WORD_W-1:0] word;
      logic                       found;
      logic                       last;
   } stack_rsp_type;

   logic                              clock;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic        [2:0]                 req_operation = lss_pkg::OP_PUSH;
   logic signed [lss_pkg::WORD_W-1:0] req_value = '0;
   logic                              rsp_strobe;
   logic        [1:0]                 rsp_status;
   logic signed [lss_pkg::WORD_W-1:0] rsp_word;
   logic                              rsp_found;
   logic                              rsp_last;

   // model of the stack contents and the responses still owed
   logic [lss_pkg::WORD_W-1:0] stack_words [lss_pkg::DEPTH];
   int                         stack_fill = 0;
   stack_rsp_type              expected_rsps [$];
   int                         error_count = 0;
   bit                         gaps_on = 1'b1;
   bit                         req_idle = 1'b1;

   lifo_stack_with_search dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_word      (rsp_word),
      .rsp_found     (rsp_found),
      .rsp_last      (rsp_last)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard limit on run time
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   // work out the responses of one accepted transaction and update the stack
   task automatic predict_stack(input logic [2:0] op, input logic [lss_pkg::WORD_W-1:0] val);
      stack_rsp_type rsp;
      bit            hit;
      int            i;
      rsp = '0;
      rsp.status = lss_pkg::STATUS_OK;
      rsp.last = 1'b1;
      case (op)
         lss_pkg::OP_PUSH: begin
            if (stack_fill >= lss_pkg::DEPTH) begin
               rsp.status = lss_pkg::STATUS_FULL;
            end else begin
               stack_words[stack_fill] = val;
               stack_fill++;
               rsp.word = val;
            end
            expected_rsps.push_back(rsp);
         end
         lss_pkg::OP_POP, lss_pkg::OP_PEEK: begin
            if (stack_fill == 0) begin
               rsp.status = lss_pkg::STATUS_EMPTY;
            end else begin
               rsp.word = stack_words[stack_fill - 1];
               if (op == lss_pkg::OP_POP) stack_fill--;
            end
            expected_rsps.push_back(rsp);
         end
         lss_pkg::OP_LIST: begin
            if (stack_fill == 0) begin
               rsp.status = lss_pkg::STATUS_EMPTY;
               expected_rsps.push_back(rsp);
            end else begin
               for (i = stack_fill; i > 0; i--) begin
                  rsp.word = stack_words[i - 1];
                  rsp.last = (i == 1);
                  expected_rsps.push_back(rsp);
               end
            end
         end
         lss_pkg::OP_SEARCH: begin
            if (stack_fill == 0) begin
               rsp.status = lss_pkg::STATUS_EMPTY;
            end else begin
               hit = 1'b0;
               for (i = 0; i < stack_fill; i++)
                  if (stack_words[i] == val) hit = 1'b1;
               rsp.found = hit;
            end
            expected_rsps.push_back(rsp);
         end
         default: ;
      endcase
   endtask

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   // extremes now and then, otherwise any word
   function automatic logic [lss_pkg::WORD_W-1:0] rand_word();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // send one transaction, wait for acceptance, then maybe idle
   task automatic send_item(input logic [2:0] op, input logic [lss_pkg::WORD_W-1:0] val);
      int gap;
      start <= 1'b1;
      req_operation <= op;
      req_value <= val;
      req_idle = 1'b0;
      do @(posedge clock); while (busy);
      predict_stack(op, val);
      gap = gap_len();
      if (gap > 0) begin
         start <= 1'b0;
         req_idle = 1'b1;
         repeat (gap) @(posedge clock);
      end
   endtask

   // operation mix: 0 leans to push, 1 leans to pop, 2 balanced
   function automatic logic [2:0] pick_op(input int bias);
      int r;
      int push_pct;
      int pop_pct;
      int rest;
      push_pct = (bias == 0) ? 60 : (bias == 1) ? 15 : 35;
      pop_pct  = (bias == 0) ? 15 : (bias == 1) ? 60 : 35;
      rest = 100 - push_pct - pop_pct;
      r = $urandom_range(0, 99);
      if (r < push_pct) return lss_pkg::OP_PUSH;
      r -= push_pct;
      if (r < pop_pct) return lss_pkg::OP_POP;
      r -= pop_pct;
      if (r < rest / 3) return lss_pkg::OP_PEEK;
      if (r < 2 * rest / 3) return lss_pkg::OP_LIST;
      return lss_pkg::OP_SEARCH;
   endfunction

   // pop, peek, list and search on an empty stack
   task automatic test_empty_stack();
      send_item(lss_pkg::OP_POP, $urandom);
      send_item(lss_pkg::OP_PEEK, $urandom);
      send_item(lss_pkg::OP_LIST, $urandom);
      send_item(lss_pkg::OP_SEARCH, 32'h0000_0000);
   endtask

   // undefined operation codes give nothing back
   task automatic test_reserved_ops();
      logic [2:0] op;
      for (op = OP_RSVD_FIRST; op != lss_pkg::OP_PUSH; op++)
         send_item(op, $urandom);
   endtask

   // extreme words through push, search, peek, list and pop
   task automatic test_extreme_words();
      send_item(lss_pkg::OP_PUSH, 32'h8000_0000);
      send_item(lss_pkg::OP_PUSH, 32'h7fff_ffff);
      send_item(lss_pkg::OP_PUSH, 32'hffff_ffff);
      send_item(lss_pkg::OP_PUSH, 32'h0000_0000);
      send_item(lss_pkg::OP_SEARCH, 32'h8000_0000);
      send_item(lss_pkg::OP_SEARCH, 32'h0000_0001);
      send_item(lss_pkg::OP_PEEK, $urandom);
      send_item(lss_pkg::OP_LIST, $urandom);
      send_item(lss_pkg::OP_POP, $urandom);
   endtask

   // fill to depth, push once more, then list and search the full stack
   task automatic test_full_stack();
      while (stack_fill < lss_pkg::DEPTH)
         send_item(lss_pkg::OP_PUSH, rand_word());
      send_item(lss_pkg::OP_PUSH, rand_word());
      send_item(lss_pkg::OP_LIST, $urandom);
      send_item(lss_pkg::OP_SEARCH, stack_words[0]);
   endtask

   // random traffic in bursts that drift between empty and full
   task automatic test_random_traffic();
      int         sent;
      int         bias;
      logic [2:0] op;
      logic [lss_pkg::WORD_W-1:0] val;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         bias = $urandom_range(0, 2);
         gaps_on = ($urandom_range(0, 3) != 0);
         repeat (20) begin
            if ($urandom_range(0, 99) < 3) begin
               op = OP_RSVD_FIRST + 3'($urandom_range(0, OP_RSVD_LAST - OP_RSVD_FIRST));
               send_item(op, $urandom);
            end else begin
               op = pick_op(bias);
               val = rand_word();
               if (op == lss_pkg::OP_SEARCH && stack_fill > 0 && $urandom_range(0, 1))
                  val = stack_words[$urandom_range(0, stack_fill - 1)];
               send_item(op, val);
               sent++;
            end
         end
      end
      gaps_on = 1'b1;
   endtask

   // report one field mismatch
   function automatic void report_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: rsp_%s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
         error_count++;
      end
   endfunction

   // response checker
   always @(posedge clock) begin : check_rsp
      stack_rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected transaction, expected none actual status %h word %h",
                     $time, rsp_status, rsp_word);
            error_count++;
         end else begin
            exp_rsp = expected_rsps.pop_front();
            report_field("status", 32'(exp_rsp.status), 32'(rsp_status));
            report_field("word", exp_rsp.word, rsp_word);
            report_field("found", 32'(exp_rsp.found), 32'(rsp_found));
            report_field("last", 32'(exp_rsp.last), 32'(rsp_last));
         end
      end
   end

   // test sequence
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_empty_stack();
      test_reserved_ops();
      test_extreme_words();
      test_full_stack();
      test_random_traffic();
      if (!req_idle) start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ files.f @@
hdl/lss_pkg.sv
hdl/lss_ram.sv
hdl/lss_ctrl.sv
hdl/lss_dp.sv
hdl/lifo_stack_with_search.sv
hdl/lss_checker.sv
bench/lifo_stack_with_search_tb.sv
